[rtl/adme_pkg.sv]
// Package for the adaptive delta modulation encoder.
// Shared widths, reset and clamp constants, pipeline control struct and a width helper.
// No dependencies.
`default_nettype none

package adme_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 16;
    localparam int STEP_W   = 15;
    localparam int THR_W    = 17;

    localparam logic [STEP_W-1:0]          STEP_RESET = 15'd839;
    localparam logic signed [SAMPLE_W-1:0] EST_MAX    = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] EST_MIN    = 16'sh8000;

    // Per-stage load strobes, driven by the top-level handshake logic
    typedef struct packed {
        logic in_xfer;
        logic adv2;
        logic adv3;
        logic adv_out;
    } pipe_ctl_t;

    // Bits needed for the sum of a full window of magnitudes
    function automatic int sum_width(input int window);
        return $clog2(window * 32768 + 1);
    endfunction

endpackage

`default_nettype wire

[rtl/adme_ifs.sv]
// Valid/ready channel interfaces for samples in and code bits out.
// Depends on adme_pkg for field widths.
`default_nettype none

interface adme_sample_if;
    import adme_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_stream;

    modport source (output valid, output sample, output last_of_stream, input ready);
    modport sink   (input valid, input sample, input last_of_stream, output ready);
endinterface

interface adme_code_if;
    logic valid;
    logic ready;
    logic code_bit;
    logic last_bit;

    modport source (output valid, output code_bit, output last_bit, input ready);
    modport sink   (input valid, input code_bit, input last_bit, output ready);
endinterface

`default_nettype wire

[rtl/adaptive_delta_mod_encoder_unit.sv]
// Adaptive one-bit delta modulation encoder, top level.
// A sample passes four registered stages in order (window sum, mean multiply,
// threshold, decision loop) before its code bit shows valid. Throughput: one
// sample per cycle while codes.ready is high; each stage stalls only when full.
// Reset: async active low; clears estimate, flag, window sum, fill count,
// pipeline valids and sets step_size to 839. Delay line contents are not reset.
`default_nettype none

module adaptive_delta_mod_encoder_unit
    import adme_pkg::*;
#(
    parameter int WINDOW = 100
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    adme_sample_if.sink            samples,
    adme_code_if.source            codes,
    input  wire logic              cfg_we,
    input  wire logic [STEP_W-1:0] cfg_wdata
);

    localparam int SUM_W = sum_width(WINDOW);

    logic [STEP_W-1:0] step_size_reg;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic vout_reg;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy_out;
    pipe_ctl_t ctl;

    logic signed [SAMPLE_W-1:0] s1_sample;
    logic                       s1_last;
    logic [SUM_W-1:0]           s1_sum;
    logic                       s1_full;
    logic signed [SAMPLE_W-1:0] s3_sample;
    logic                       s3_last;
    logic [THR_W-1:0]           s3_thr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            step_size_reg <= cfg_wdata;
        end
    end

    // A stage can load when it is empty or its content moves on
    assign rdy_out = !vout_reg || codes.ready;
    assign rdy3    = !v3_reg || rdy_out;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;

    assign ctl.in_xfer = rdy1 && samples.valid;
    assign ctl.adv2    = rdy2 && v1_reg;
    assign ctl.adv3    = rdy3 && v2_reg;
    assign ctl.adv_out = rdy_out && v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= samples.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy_out)
            begin
                vout_reg <= v3_reg;
            end
        end
    end

    assign samples.ready = rdy1;
    assign codes.valid   = vout_reg;

    adme_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sample         (samples.sample),
        .last_of_stream (samples.last_of_stream),
        .s1_sample      (s1_sample),
        .s1_last        (s1_last),
        .s1_sum         (s1_sum),
        .s1_full        (s1_full)
    );

    adme_thresh #(
        .WINDOW (WINDOW)
    ) u_thresh (
        .clk       (clk),
        .ctl       (ctl),
        .step_size (step_size_reg),
        .s1_sample (s1_sample),
        .s1_last   (s1_last),
        .s1_sum    (s1_sum),
        .s1_full   (s1_full),
        .s3_sample (s3_sample),
        .s3_last   (s3_last),
        .s3_thr    (s3_thr)
    );

    adme_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .step_size (step_size_reg),
        .s3_sample (s3_sample),
        .s3_last   (s3_last),
        .s3_thr    (s3_thr),
        .code_bit  (codes.code_bit),
        .last_bit  (codes.last_bit)
    );

endmodule

`default_nettype wire

[rtl/adme_cell.sv]
// One cell of the magnitude delay line: holds one sample magnitude.
// Depends on adme_pkg.
`default_nettype none

module adme_cell
    import adme_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             shift_en,
    input  wire logic [MAG_W-1:0] d,
    output logic      [MAG_W-1:0] q
);

    logic [MAG_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

[rtl/adme_window.sv]
// Sliding window of sample magnitudes: chain of adme_cell, running sum, fill count.
// First pipeline stage. Depends on adme_pkg and adme_cell.
`default_nettype none

module adme_window
    import adme_pkg::*;
#(
    parameter int WINDOW = 100,
    localparam int SUM_W = sum_width(WINDOW)
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire pipe_ctl_t                  ctl,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic                       last_of_stream,
    output logic signed [SAMPLE_W-1:0]      s1_sample,
    output logic                            s1_last,
    output logic [SUM_W-1:0]                s1_sum,
    output logic                            s1_full
);

    localparam int FILL_W = $clog2(WINDOW + 1);

    logic [MAG_W-1:0]  mag;
    logic [MAG_W-1:0]  tap [WINDOW];
    logic              full;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic                       s1_last_reg;
    logic [SUM_W-1:0]           s1_sum_reg;
    logic                       s1_full_reg;

    // Most negative sample maps to 0x8000, which is its true magnitude
    assign mag = sample[SAMPLE_W-1] ? MAG_W'(~sample + 1'b1) : MAG_W'(sample);

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                adme_cell u_cell (
                    .clk      (clk),
                    .shift_en (ctl.in_xfer),
                    .d        (mag),
                    .q        (tap[gi])
                );
            end
            else
            begin : g_body
                adme_cell u_cell (
                    .clk      (clk),
                    .shift_en (ctl.in_xfer),
                    .d        (tap[gi-1]),
                    .q        (tap[gi])
                );
            end
        end
    endgenerate

    assign full = (fill_reg == FILL_W'(WINDOW));

    // Drop the oldest magnitude once the window is full
    assign sum_next = sum_reg + SUM_W'(mag) - (full ? SUM_W'(tap[WINDOW-1]) : '0);

    assign fill_next = full ? fill_reg : fill_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            fill_reg <= '0;
        end
        else if (ctl.in_xfer)
        begin
            sum_reg  <= last_of_stream ? '0 : sum_next;
            fill_reg <= last_of_stream ? '0 : fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.in_xfer)
        begin
            s1_sample_reg <= sample;
            s1_last_reg   <= last_of_stream;
            s1_sum_reg    <= sum_next;
            s1_full_reg   <= full;
        end
    end

    assign s1_sample = s1_sample_reg;
    assign s1_last   = s1_last_reg;
    assign s1_sum    = s1_sum_reg;
    assign s1_full   = s1_full_reg;

endmodule

`default_nettype wire

[rtl/adme_thresh.sv]
// Window mean by reciprocal multiply, then decision threshold.
// Second and third pipeline stages. Depends on adme_pkg.
`default_nettype none

module adme_thresh
    import adme_pkg::*;
#(
    parameter int WINDOW = 100,
    localparam int SUM_W = sum_width(WINDOW)
)
(
    input  wire logic                       clk,
    input  wire pipe_ctl_t                  ctl,
    input  wire logic [STEP_W-1:0]          step_size,
    input  wire logic signed [SAMPLE_W-1:0] s1_sample,
    input  wire logic                       s1_last,
    input  wire logic [SUM_W-1:0]           s1_sum,
    input  wire logic                       s1_full,
    output logic signed [SAMPLE_W-1:0]      s3_sample,
    output logic                            s3_last,
    output logic [THR_W-1:0]                s3_thr
);

    // floor(x / WINDOW) == (x * RECIP) >> SH for every x below 2**SUM_W
    localparam int LOG_W   = $clog2(WINDOW);
    localparam int SH      = SUM_W + LOG_W;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic [PROD_W-1:0] prod;

    logic signed [SAMPLE_W-1:0] s2_sample_reg;
    logic                       s2_last_reg;
    logic                       s2_full_reg;
    logic [MAG_W-1:0]           s2_mean_reg;

    logic signed [SAMPLE_W-1:0] s3_sample_reg;
    logic                       s3_last_reg;
    logic [THR_W-1:0]           s3_thr_reg;

    assign prod = PROD_W'(s1_sum) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (ctl.adv2)
        begin
            s2_sample_reg <= s1_sample;
            s2_last_reg   <= s1_last;
            s2_full_reg   <= s1_full;
            s2_mean_reg   <= prod[SH +: MAG_W];
        end
    end

    // Bare step size until the window has filled
    always_ff @(posedge clk)
    begin
        if (ctl.adv3)
        begin
            s3_sample_reg <= s2_sample_reg;
            s3_last_reg   <= s2_last_reg;
            s3_thr_reg    <= THR_W'(step_size)
                             + (s2_full_reg ? THR_W'(s2_mean_reg) : '0);
        end
    end

    assign s3_sample = s3_sample_reg;
    assign s3_last   = s3_last_reg;
    assign s3_thr    = s3_thr_reg;

endmodule

`default_nettype wire

[rtl/adme_decide.sv]
// Decision loop: estimate, alternate flag, code bit; drives the output register.
// Last pipeline stage. Depends on adme_pkg.
`default_nettype none

module adme_decide
    import adme_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire pipe_ctl_t                  ctl,
    input  wire logic [STEP_W-1:0]          step_size,
    input  wire logic signed [SAMPLE_W-1:0] s3_sample,
    input  wire logic                       s3_last,
    input  wire logic [THR_W-1:0]           s3_thr,
    output logic                            code_bit,
    output logic                            last_bit
);

    logic signed [SAMPLE_W-1:0] est_reg;
    logic signed [SAMPLE_W-1:0] est_next;
    logic                       toggle_reg;
    logic                       toggle_next;
    logic                       code_bit_reg;
    logic                       last_bit_reg;

    logic signed [SAMPLE_W:0]   dlt;
    logic [THR_W-1:0]           adlt;
    logic                       bit_c;
    logic signed [SAMPLE_W+1:0] est_w;
    logic signed [SAMPLE_W+1:0] step_w;
    logic signed [SAMPLE_W+1:0] moved;
    logic signed [SAMPLE_W-1:0] clamped;

    always_comb
    begin
        dlt    = {s3_sample[SAMPLE_W-1], s3_sample} - {est_reg[SAMPLE_W-1], est_reg};
        adlt   = dlt[SAMPLE_W] ? THR_W'(-dlt) : THR_W'(dlt);
        // Small delta: follow the alternate flag, else the sign of the delta
        bit_c  = (adlt < s3_thr) ? toggle_reg : ~dlt[SAMPLE_W];
        est_w  = {{2{est_reg[SAMPLE_W-1]}}, est_reg};
        step_w = {3'b000, step_size};
        moved  = bit_c ? est_w + step_w : est_w - step_w;
        priority if (moved > 18'sd32767)
        begin
            clamped = EST_MAX;
        end
        else if (moved < -18'sd32768)
        begin
            clamped = EST_MIN;
        end
        else
        begin
            clamped = moved[SAMPLE_W-1:0];
        end
        // Flag ends as the complement of the emitted bit, or cleared on the last sample
        est_next    = s3_last ? '0 : clamped;
        toggle_next = s3_last ? 1'b0 : ~bit_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg    <= '0;
            toggle_reg <= 1'b0;
        end
        else if (ctl.adv_out)
        begin
            est_reg    <= est_next;
            toggle_reg <= toggle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv_out)
        begin
            code_bit_reg <= bit_c;
            last_bit_reg <= s3_last;
        end
    end

    assign code_bit = code_bit_reg;
    assign last_bit = last_bit_reg;

endmodule

`default_nettype wire

[rtl/adme_checker.sv]
// Port-level checker for the encoder top level, attached by bind.
// Depends on adaptive_delta_mod_encoder_unit ports only.
`default_nettype none

module adme_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic code_bit,
    input wire logic last_bit
);

    logic [2:0] in_flight_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // Track samples taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_flight_reg <= '0;
        end
        else
        begin
            in_flight_reg <= in_flight_reg + {2'b00, in_xfer} - {2'b00, out_xfer};
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_bit) && $stable(last_bit))
        else $error("code transfer dropped or changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight_reg == 3'd0 |-> !out_valid)
        else $error("code bit shown with no sample outstanding");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight_reg <= 3'd4)
        else $error("more samples held than pipeline stages");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready && in_flight_reg == 3'd4)
        else $error("input stalled while pipeline has room");

endmodule

bind adaptive_delta_mod_encoder_unit adme_checker u_adme_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (codes.valid),
    .out_ready (codes.ready),
    .code_bit  (codes.code_bit),
    .last_bit  (codes.last_bit)
);

`default_nettype wire
